### design/fbsp_pkg.sv
// ----------------------------------------------------------------------------
// fbsp_pkg
// Shared types, register map and constants of the four-band splitter.
// ----------------------------------------------------------------------------
package fbsp_pkg;

  localparam int SampleBitsDefault = 16;

  localparam int CoefW    = 16;
  localparam int FloorW   = 15;
  localparam int PeakOutW = 15;
  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;

  // Q2.14 band gains
  localparam logic [CoefW-1:0] GainBass    = 16'd18022;
  localparam logic [CoefW-1:0] GainLowmid  = 16'd18842;
  localparam logic [CoefW-1:0] GainHighmid = 16'd19661;
  localparam logic [CoefW-1:0] GainTreble  = 16'd20480;

  localparam logic [CoefW-1:0] BassCoefRst    = 16'd3604;
  localparam logic [CoefW-1:0] LowmidCoefRst  = 16'd11796;
  localparam logic [CoefW-1:0] HighmidCoefRst = 16'd29491;
  localparam logic [CoefW-1:0] AttackCoefRst  = 16'd9830;
  localparam logic [CoefW-1:0] ReleaseCoefRst = 16'd1311;
  localparam logic [FloorW-1:0] PeakFloorRst  = 15'd6554;

  typedef enum logic [2:0] {
    REG_BASS    = 3'd0,
    REG_LOWMID  = 3'd1,
    REG_HIGHMID = 3'd2,
    REG_ATTACK  = 3'd3,
    REG_RELEASE = 3'd4,
    REG_FLOOR   = 3'd5
  } reg_idx_e;

  // One operation per pass through the shared multiplier
  typedef enum logic [2:0] {
    OP_F1 = 3'd0,
    OP_F2 = 3'd1,
    OP_F3 = 3'd2,
    OP_B1 = 3'd3,
    OP_B2 = 3'd4,
    OP_B3 = 3'd5,
    OP_B4 = 3'd6,
    OP_PK = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_FIN  = 2'd2
  } state_e;

  typedef struct packed {
    logic [CoefW-1:0]  bass;
    logic [CoefW-1:0]  lowmid;
    logic [CoefW-1:0]  highmid;
    logic [CoefW-1:0]  attack;
    logic [CoefW-1:0]  rel;
    logic [FloorW-1:0] pk_floor;
  } cfg_t;

  typedef struct packed {
    logic load;    // capture the input beat
    logic issue;   // start a multiply
    op_e  op;      // operation being issued
    logic post;    // retire the previous multiply
    logic finish;  // retire the peak step and load the output register
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

### design/fbsp_csr.sv
// ----------------------------------------------------------------------------
// fbsp_csr
// APB register file holding filter and peak follower coefficients.
// ----------------------------------------------------------------------------
module fbsp_csr import fbsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_BASS:    cfg_d.bass     = pwdata[CoefW-1:0];
        REG_LOWMID:  cfg_d.lowmid   = pwdata[CoefW-1:0];
        REG_HIGHMID: cfg_d.highmid  = pwdata[CoefW-1:0];
        REG_ATTACK:  cfg_d.attack   = pwdata[CoefW-1:0];
        REG_RELEASE: cfg_d.rel      = pwdata[CoefW-1:0];
        REG_FLOOR:   cfg_d.pk_floor = pwdata[FloorW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASS:    prdata = ApbDataW'(cfg_q.bass);
      REG_LOWMID:  prdata = ApbDataW'(cfg_q.lowmid);
      REG_HIGHMID: prdata = ApbDataW'(cfg_q.highmid);
      REG_ATTACK:  prdata = ApbDataW'(cfg_q.attack);
      REG_RELEASE: prdata = ApbDataW'(cfg_q.rel);
      REG_FLOOR:   prdata = ApbDataW'(cfg_q.pk_floor);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bass     <= BassCoefRst;
      cfg_q.lowmid   <= LowmidCoefRst;
      cfg_q.highmid  <= HighmidCoefRst;
      cfg_q.attack   <= AttackCoefRst;
      cfg_q.rel      <= ReleaseCoefRst;
      cfg_q.pk_floor <= PeakFloorRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### design/fbsp_ctrl.sv
// ----------------------------------------------------------------------------
// fbsp_ctrl
// Sequencer: steps the shared multiplier through the eight operations of a beat.
// ----------------------------------------------------------------------------
module fbsp_ctrl import fbsp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e     state_q, state_d;
  logic [2:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '{load: 1'b0, issue: 1'b0, op: OP_F1, post: 1'b0, finish: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = op_e'(step_q);
        cmd_o.post  = (op_e'(step_q) != OP_F1);
        step_d      = step_q + 3'd1;
        if (op_e'(step_q) == OP_PK) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait for room in the output register
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### design/fbsp_dpath.sv
// ----------------------------------------------------------------------------
// fbsp_dpath
// Filter, band and peak datapath around one shared signed multiplier.
// ----------------------------------------------------------------------------
module fbsp_dpath import fbsp_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmd_t                          cmd_i,
  output status_t                       status_o,
  input  cfg_t                          cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input  logic                          window_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] mono_out_o,
  output logic signed [SAMPLE_BITS-1:0] bass_out_o,
  output logic signed [SAMPLE_BITS-1:0] lowmid_out_o,
  output logic signed [SAMPLE_BITS-1:0] highmid_out_o,
  output logic signed [SAMPLE_BITS-1:0] treble_out_o,
  output logic [PeakOutW-1:0]           smoothed_peak_o,
  output logic                          window_done_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int ProdW = SB + 18;
  localparam int PeakW = ((SB > 16) ? SB : 16) + 1;
  localparam int FullScale = 1 << (SB - 1);
  localparam logic [SB-1:0]    WpReset   = SB'((FullScale + 50) / 100);
  localparam logic [SB-2:0]    SpReset   = (SB-1)'((FullScale * 7 + 5) / 10);
  localparam logic [PeakW-1:0] SpMax     = PeakW'(FullScale - 1);
  localparam logic [PeakW-1:0] OutCap    = PeakW'((1 << PeakOutW) - 1);
  localparam logic [ProdW-1:0] BandRound = ProdW'(8192);

  // beat state
  logic signed [SB-1:0] mono_q, lp1_q, lp2_q, lp3_q;
  logic [SB-1:0]        wp_q;
  logic [SB-2:0]        sp_q;
  logic                 last_q;
  logic signed [SB-1:0] band1_q, band2_q, band3_q, band4_q;

  // multiplier
  logic signed [SB:0]      op_a;
  logic [CoefW-1:0]        op_b;
  logic signed [ProdW-1:0] prod_d, prod_q;
  op_e                     pend_op_q;

  // output register
  logic                 out_valid_q;
  logic signed [SB-1:0] mono_o_q, bass_o_q, lowmid_o_q, highmid_o_q, treble_o_q;
  logic [PeakOutW-1:0]  peak_o_q;
  logic                 done_o_q;

  logic signed [SB:0]   sum_w;
  logic signed [SB-1:0] mono_w;
  logic [SB-1:0]        mag_w;
  logic [PeakW-1:0]     wp_ext, sp_ext, diff_w, step_w, sp_calc, sp_new, sp_fin;
  logic                 up_w;
  logic [ProdW-1:0]     rnd_w;
  logic [SB+3:0]        sh_w;
  logic [4:0]           sh_hi;
  logic signed [SB-1:0] band_w;

  function automatic logic signed [SB:0] sx(input logic signed [SB-1:0] v);
    sx = $signed({v[SB-1], v});
  endfunction

  // mono and its magnitude; most negative value maps to full scale
  assign sum_w  = sx(left_sample_i) + sx(right_sample_i);
  assign mono_w = sum_w[SB:1];
  assign mag_w  = mono_w[SB-1] ? (~mono_w + 1'b1) : mono_w;

  // peak follower decision, stable from issue of the peak step to finish
  assign wp_ext = PeakW'(wp_q);
  assign sp_ext = PeakW'(sp_q);
  assign up_w   = wp_ext > sp_ext;
  assign diff_w = up_w ? (wp_ext - sp_ext) : (sp_ext - wp_ext);
  assign step_w = PeakW'(prod_q[SB+14:16]);

  always_comb begin
    sp_calc = up_w ? (sp_ext + step_w) : (sp_ext - step_w);
    sp_new  = sp_calc;
    if (sp_new < PeakW'(cfg_i.pk_floor)) begin
      sp_new = PeakW'(cfg_i.pk_floor);
    end
    if (sp_new > SpMax) begin
      sp_new = SpMax;
    end
    sp_fin = last_q ? sp_new : sp_ext;
  end

  // band rounding and saturation
  always_comb begin
    rnd_w = prod_q + BandRound;
    sh_w  = rnd_w[ProdW-1:14];
    sh_hi = sh_w[SB+3:SB-1];
    if ((&sh_hi) || !(|sh_hi)) begin
      band_w = sh_w[SB-1:0];
    end else if (sh_w[SB+3]) begin
      band_w = {1'b1, {(SB-1){1'b0}}};
    end else begin
      band_w = {1'b0, {(SB-1){1'b1}}};
    end
  end

  // operand select
  always_comb begin
    case (cmd_i.op)
      OP_F1: begin op_a = sx(mono_q) - sx(lp1_q); op_b = cfg_i.bass;    end
      OP_F2: begin op_a = sx(mono_q) - sx(lp2_q); op_b = cfg_i.lowmid;  end
      OP_F3: begin op_a = sx(mono_q) - sx(lp3_q); op_b = cfg_i.highmid; end
      OP_B1: begin op_a = sx(lp1_q);              op_b = GainBass;      end
      OP_B2: begin op_a = sx(lp2_q) - sx(lp1_q);  op_b = GainLowmid;    end
      OP_B3: begin op_a = sx(lp3_q) - sx(lp2_q);  op_b = GainHighmid;   end
      OP_B4: begin op_a = sx(mono_q) - sx(lp3_q); op_b = GainTreble;    end
      OP_PK: begin
        op_a = $signed({1'b0, diff_w[SB-1:0]});
        op_b = up_w ? cfg_i.attack : cfg_i.rel;
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod_d = op_a * $signed({1'b0, op_b});

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      prod_q    <= prod_d;
      pend_op_q <= cmd_i.op;
    end
    if (cmd_i.load) begin
      mono_q <= mono_w;
      last_q <= window_end_i;
    end
    if (cmd_i.post) begin
      case (pend_op_q)
        OP_B1:   band1_q <= band_w;
        OP_B2:   band2_q <= band_w;
        OP_B3:   band3_q <= band_w;
        OP_B4:   band4_q <= band_w;
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      mono_o_q    <= mono_q;
      bass_o_q    <= band1_q;
      lowmid_o_q  <= band2_q;
      highmid_o_q <= band3_q;
      treble_o_q  <= band4_q;
      peak_o_q    <= (sp_fin > OutCap) ? OutCap[PeakOutW-1:0] : sp_fin[PeakOutW-1:0];
      done_o_q    <= last_q;
    end
  end

  // filter and peak state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp1_q <= '0;
      lp2_q <= '0;
      lp3_q <= '0;
      wp_q  <= WpReset;
      sp_q  <= SpReset;
    end else begin
      if (cmd_i.load && (mag_w > wp_q)) begin
        wp_q <= mag_w;
      end
      if (cmd_i.post) begin
        case (pend_op_q)
          OP_F1:   lp1_q <= lp1_q + $signed(prod_q[SB+15:16]);
          OP_F2:   lp2_q <= lp2_q + $signed(prod_q[SB+15:16]);
          OP_F3:   lp3_q <= lp3_q + $signed(prod_q[SB+15:16]);
          default: ;
        endcase
      end
      if (cmd_i.finish && last_q) begin
        sp_q  <= sp_new[SB-2:0];
        lp1_q <= '0;
        lp2_q <= '0;
        lp3_q <= '0;
        wp_q  <= WpReset;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign mono_out_o      = mono_o_q;
  assign bass_out_o      = bass_o_q;
  assign lowmid_out_o    = lowmid_o_q;
  assign highmid_out_o   = highmid_o_q;
  assign treble_out_o    = treble_o_q;
  assign smoothed_peak_o = peak_o_q;
  assign window_done_o   = done_o_q;

endmodule

### design/four_band_splitter_peak_follower.sv
// ----------------------------------------------------------------------------
// four_band_splitter_peak_follower
// Stereo-to-mono four-band crossover with windowed peak follower.
// ----------------------------------------------------------------------------
// Beats are taken one at a time: a new beat is accepted only after the last
//   one has made eight passes through the one shared multiplier (three filter
//   steps, four band gains, one peak step) and reached the output register.
// A finished result waits in the output register while the next beat runs.
// Reset (async, active low): coefficients to defaults, filters cleared,
//   window peak to 0.01 and smoothed peak to 0.7 of full scale.
module four_band_splitter_peak_follower import fbsp_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ApbAddrW-1:0]           paddr,
  input  logic [ApbDataW-1:0]           pwdata,
  output logic [ApbDataW-1:0]           prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input  logic                          window_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] mono_out_o,
  output logic signed [SAMPLE_BITS-1:0] bass_out_o,
  output logic signed [SAMPLE_BITS-1:0] lowmid_out_o,
  output logic signed [SAMPLE_BITS-1:0] highmid_out_o,
  output logic signed [SAMPLE_BITS-1:0] treble_out_o,
  output logic [PeakOutW-1:0]           smoothed_peak_o,
  output logic                          window_done_o
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  fbsp_csr u_csr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fbsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fbsp_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_i           (cfg),
    .left_sample_i   (left_sample_i),
    .right_sample_i  (right_sample_i),
    .window_end_i    (window_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .mono_out_o      (mono_out_o),
    .bass_out_o      (bass_out_o),
    .lowmid_out_o    (lowmid_out_o),
    .highmid_out_o   (highmid_out_o),
    .treble_out_o    (treble_out_o),
    .smoothed_peak_o (smoothed_peak_o),
    .window_done_o   (window_done_o)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-band splitter with peak follower: stereo
// beats go in through a randomly throttled driver, every result beat is
// compared against a cycle-free predictor, and the APB registers are swept
// through reset, extreme and random settings between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import fbsp_pkg::*;

  localparam int     SW          = SampleBitsDefault;
  localparam longint FullScale   = longint'(1) << (SW - 1);
  localparam longint SampleMax   = FullScale - 1;
  localparam longint SampleMin   = -FullScale;
  localparam longint WinPeakRst  = (FullScale + 50) / 100;
  localparam longint SmoothRst   = (FullScale * 7 + 5) / 10;
  localparam longint PeakCap     = (longint'(1) << PeakOutW) - 1;
  localparam int     PhaseItems  = 110;
  localparam int     RandPhases  = 8;
  localparam int     DrainCycles = 20;
  localparam int     CycleLimit  = 400_000;

  // register indexes that decode to nothing
  localparam logic [2:0] RegUnusedLo = 3'd6;
  localparam logic [2:0] RegUnusedHi = 3'd7;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t RailHi = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t RailLo = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 last;
  } stereo_beat_t;

  typedef struct packed {
    logic signed [SW-1:0] mono;
    logic signed [SW-1:0] bass;
    logic signed [SW-1:0] lowmid;
    logic signed [SW-1:0] highmid;
    logic signed [SW-1:0] treble;
    logic [PeakOutW-1:0]  peak;
    logic                 done;
  } band_set_t;

  typedef enum int {AMP_FULL, AMP_SCALED, AMP_RAIL, AMP_STEADY} amp_kind_e;
  typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_HEAVY} idle_kind_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel, penable, pwrite;
  logic [ApbAddrW-1:0]  paddr;
  logic [ApbDataW-1:0]  pwdata;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;
  logic                 in_valid_i, in_ready_o;
  sample_t              left_sample_i, right_sample_i;
  logic                 window_end_i;
  logic                 out_valid_o, out_ready_i;
  sample_t              mono_out_o, bass_out_o, lowmid_out_o, highmid_out_o, treble_out_o;
  logic [PeakOutW-1:0]  smoothed_peak_o;
  logic                 window_done_o;

  four_band_splitter_peak_follower #(.SAMPLE_BITS(SW)) u_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .left_sample_i, .right_sample_i, .window_end_i,
    .out_valid_o, .out_ready_i, .mono_out_o, .bass_out_o, .lowmid_out_o,
    .highmid_out_o, .treble_out_o, .smoothed_peak_o, .window_done_o
  );

  // predictor state and register shadow
  cfg_t   crossover_cfg = '{bass: BassCoefRst, lowmid: LowmidCoefRst,
                            highmid: HighmidCoefRst, attack: AttackCoefRst,
                            rel: ReleaseCoefRst, pk_floor: PeakFloorRst};
  longint lp_one = 0, lp_two = 0, lp_three = 0;
  longint win_peak = WinPeakRst;
  longint smooth_peak = SmoothRst;

  stereo_beat_t pending_beats[$];
  band_set_t    expected_bands[$];
  stereo_beat_t cur_beat;
  band_set_t    want_bands, seen_bands;

  bit         beat_busy, in_taken, out_taken;
  int         send_gap, recv_stall;
  idle_kind_e send_mode = IDLE_SPARSE, recv_mode = IDLE_SPARSE;
  int         mismatches, beats_accepted, results_seen, windows_closed;
  int         settings_applied, cycle_count;

  function automatic sample_t gain_and_clip(longint diff, longint gain);
    longint v;
    v = (diff * gain + 8192) >>> 14;
    if (v > SampleMax) v = SampleMax;
    else if (v < SampleMin) v = SampleMin;
    return v[SW-1:0];
  endfunction

  function automatic band_set_t split_and_follow(stereo_beat_t b);
    band_set_t r;
    longint    mono, mag, sp;
    mono     = (longint'(b.left) + longint'(b.right)) >>> 1;
    lp_one   = lp_one + ((longint'(crossover_cfg.bass) * (mono - lp_one)) >>> 16);
    lp_two   = lp_two + ((longint'(crossover_cfg.lowmid) * (mono - lp_two)) >>> 16);
    lp_three = lp_three + ((longint'(crossover_cfg.highmid) * (mono - lp_three)) >>> 16);
    r.mono    = mono[SW-1:0];
    r.bass    = gain_and_clip(lp_one, longint'(GainBass));
    r.lowmid  = gain_and_clip(lp_two - lp_one, longint'(GainLowmid));
    r.highmid = gain_and_clip(lp_three - lp_two, longint'(GainHighmid));
    r.treble  = gain_and_clip(mono - lp_three, longint'(GainTreble));
    // most negative mono keeps its full-scale magnitude
    mag = (mono < 0) ? -mono : mono;
    if (mag > win_peak) win_peak = mag;
    if (b.last) begin
      sp = smooth_peak;
      if (win_peak > sp) sp = sp + ((longint'(crossover_cfg.attack) * (win_peak - sp)) >> 16);
      else sp = sp - ((longint'(crossover_cfg.rel) * (sp - win_peak)) >> 16);
      if (sp < longint'(crossover_cfg.pk_floor)) sp = longint'(crossover_cfg.pk_floor);
      if (sp > SampleMax) sp = SampleMax;
      smooth_peak = sp;
      lp_one      = 0;
      lp_two      = 0;
      lp_three    = 0;
      win_peak    = WinPeakRst;
    end
    r.peak = (smooth_peak > PeakCap) ? PeakCap[PeakOutW-1:0] : smooth_peak[PeakOutW-1:0];
    r.done = b.last;
    return r;
  endfunction

  function automatic int draw_gap(idle_kind_e mode);
    case (mode)
      IDLE_SPARSE: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
      IDLE_HEAVY:  return $urandom_range(0, 19);
      default:     return 0;
    endcase
  endfunction

  function automatic sample_t draw_sample(amp_kind_e kind, int shift, sample_t level);
    sample_t s;
    s = sample_t'($urandom);
    case (kind)
      AMP_SCALED: s = s >>> shift;
      AMP_RAIL:   s = s[SW-1] ? RailLo : RailHi;
      AMP_STEADY: s = level;
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [CoefW-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CoefW'($urandom);
    endcase
  endfunction

  task automatic check_field(string what, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  task automatic push_beat(sample_t l, sample_t r, logic last);
    pending_beats.push_back('{left: l, right: r, last: last});
  endtask

  task automatic apb_write(logic [2:0] idx, logic [ApbDataW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_BASS:    crossover_cfg.bass     = val[CoefW-1:0];
      REG_LOWMID:  crossover_cfg.lowmid   = val[CoefW-1:0];
      REG_HIGHMID: crossover_cfg.highmid  = val[CoefW-1:0];
      REG_ATTACK:  crossover_cfg.attack   = val[CoefW-1:0];
      REG_RELEASE: crossover_cfg.rel      = val[CoefW-1:0];
      REG_FLOOR:   crossover_cfg.pk_floor = val[FloorW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(logic [2:0] idx, output logic [ApbDataW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    val = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // all writes carry junk above the field width; it must be dropped
  task automatic apply_setting(cfg_t c, bit do_write);
    logic [ApbDataW-1:0] junk, rd;
    longint              held;
    junk = $urandom;
    if (do_write) begin
      apb_write(REG_BASS,    {junk[31:16], c.bass});
      apb_write(REG_LOWMID,  {junk[31:16], c.lowmid});
      apb_write(REG_HIGHMID, {junk[31:16], c.highmid});
      apb_write(REG_ATTACK,  {junk[31:16], c.attack});
      apb_write(REG_RELEASE, {junk[31:16], c.rel});
      apb_write(REG_FLOOR,   {junk[31:15], c.pk_floor});
      apb_write(RegUnusedLo, $urandom);
      apb_write(RegUnusedHi, $urandom);
      settings_applied++;
    end
    for (int i = REG_BASS; i <= REG_FLOOR; i++) begin
      apb_read(i[2:0], rd);
      case (i[2:0])
        REG_BASS:    held = crossover_cfg.bass;
        REG_LOWMID:  held = crossover_cfg.lowmid;
        REG_HIGHMID: held = crossover_cfg.highmid;
        REG_ATTACK:  held = crossover_cfg.attack;
        REG_RELEASE: held = crossover_cfg.rel;
        default:     held = crossover_cfg.pk_floor;
      endcase
      check_field($sformatf("register %0d readback", i), held,
                  (i[2:0] == REG_FLOOR) ? rd[FloorW-1:0] : rd[CoefW-1:0]);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || beat_busy || expected_bands.size() != 0);
  endtask

  task automatic queue_random_windows(int n_items);
    int        left_to_go, len, shift;
    amp_kind_e kind;
    sample_t   level;
    left_to_go = n_items;
    while (left_to_go > 0) begin
      len   = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
      kind  = amp_kind_e'($urandom_range(AMP_FULL, AMP_STEADY));
      shift = $urandom_range(1, SW - 2);
      level = sample_t'($urandom);
      for (int k = 0; k < len && left_to_go > 0; k++) begin
        push_beat(draw_sample(kind, shift, level), draw_sample(kind, shift, level), k == len - 1);
        left_to_go--;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles, %0d results still owed",
               cycle_count, expected_bands.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input side: note each accepted beat and predict its result
  always @(posedge clk_i) begin : beat_sampler
    if (rst_ni && in_valid_i && in_ready_o) begin
      in_taken = 1'b1;
      beats_accepted++;
      if (window_end_i) windows_closed++;
      expected_bands.push_back(split_and_follow('{left: left_sample_i,
                                                  right: right_sample_i,
                                                  last: window_end_i}));
    end
  end

  always @(negedge clk_i) begin : beat_driver
    if (rst_ni) begin
      if (in_taken) begin
        in_taken  = 1'b0;
        beat_busy = 1'b0;
        send_gap  = draw_gap(send_mode);
      end
      if (!beat_busy) begin
        if (send_gap > 0) send_gap--;
        else if (pending_beats.size() != 0) begin
          cur_beat       = pending_beats.pop_front();
          beat_busy      = 1'b1;
          left_sample_i  <= cur_beat.left;
          right_sample_i <= cur_beat.right;
          window_end_i   <= cur_beat.last;
        end
      end
      in_valid_i <= beat_busy;
    end
  end

  always @(negedge clk_i) begin : result_sink
    if (rst_ni) begin
      if (out_taken) begin
        out_taken  = 1'b0;
        recv_stall = draw_gap(recv_mode);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_taken = 1'b1;
      results_seen++;
      seen_bands = '{mono: mono_out_o, bass: bass_out_o, lowmid: lowmid_out_o,
                     highmid: highmid_out_o, treble: treble_out_o,
                     peak: smoothed_peak_o, done: window_done_o};
      if (expected_bands.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH result beat %0d arrived with nothing outstanding", results_seen);
      end else begin
        want_bands = expected_bands.pop_front();
        check_field($sformatf("beat %0d mono", results_seen), want_bands.mono, seen_bands.mono);
        check_field($sformatf("beat %0d bass", results_seen), want_bands.bass, seen_bands.bass);
        check_field($sformatf("beat %0d lowmid", results_seen),
                    want_bands.lowmid, seen_bands.lowmid);
        check_field($sformatf("beat %0d highmid", results_seen),
                    want_bands.highmid, seen_bands.highmid);
        check_field($sformatf("beat %0d treble", results_seen),
                    want_bands.treble, seen_bands.treble);
        check_field($sformatf("beat %0d peak", results_seen), want_bands.peak, seen_bands.peak);
        check_field($sformatf("beat %0d window_done", results_seen),
                    want_bands.done, seen_bands.done);
      end
    end
  end

  initial begin
    cfg_t setting;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    left_sample_i  = '0;
    right_sample_i = '0;
    window_end_i   = 1'b0;
    out_ready_i    = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values read back, then directed corners on the default setting
    apply_setting(crossover_cfg, 1'b0);
    push_beat(0, 0, 1'b0);
    push_beat(RailHi, RailHi, 1'b0);
    push_beat(RailHi, RailHi, 1'b0);
    push_beat(RailLo, RailLo, 1'b0);
    push_beat(RailLo, RailLo, 1'b1);   // full-scale negative peak, attack
    push_beat(RailHi, RailLo, 1'b0);   // mono rounds down to -1
    push_beat(RailLo, RailHi, 1'b0);
    push_beat(1, 0, 1'b0);
    push_beat(-1, 0, 1'b0);
    push_beat(0, -1, 1'b0);
    push_beat(100, -50, 1'b1);         // quiet window, release
    push_beat(RailLo, RailLo, 1'b0);
    push_beat(RailLo, RailLo, 1'b0);
    push_beat(RailLo, RailLo, 1'b0);
    push_beat(RailHi, RailHi, 1'b0);   // step drives treble into the rail
    push_beat(RailHi, RailHi, 1'b0);
    push_beat(16384, -16384, 1'b1);
    push_beat(0, 0, 1'b1);             // window of one silent beat
    push_beat(RailHi, RailHi, 1'b1);
    push_beat(21845, -21846, 1'b0);
    push_beat(-21846, 21845, 1'b1);

    for (int p = 0; p < RandPhases; p++) begin
      wait_drained();
      case (p)
        0: setting = '1;
        1: setting = '0;
        default: begin
          setting.bass     = pick_coef();
          setting.lowmid   = pick_coef();
          setting.highmid  = pick_coef();
          setting.attack   = pick_coef();
          setting.rel      = pick_coef();
          setting.pk_floor = FloorW'(pick_coef() >> 1);
        end
      endcase
      apply_setting(setting, 1'b1);
      send_mode = (p == 0) ? IDLE_NONE : idle_kind_e'($urandom_range(IDLE_NONE, IDLE_HEAVY));
      recv_mode = (p == 0) ? IDLE_NONE : idle_kind_e'($urandom_range(IDLE_NONE, IDLE_HEAVY));
      queue_random_windows(PhaseItems);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Ran %0d stereo beats, %0d windows closed, %0d register settings written",
             beats_accepted, windows_closed, settings_applied);
    $display("Checked %0d result beats, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expected_bands.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### four_band_splitter_peak_follower.f
design/fbsp_pkg.sv
design/fbsp_csr.sv
design/fbsp_ctrl.sv
design/fbsp_dpath.sv
design/four_band_splitter_peak_follower.sv
verif/tb_top.sv
